### src/lbmc_pkg.sv
package lbmc_pkg;

  localparam int unsigned LightW   = 8;
  localparam int unsigned MotorW   = 9;
  localparam int unsigned CheckW   = 8;
  localparam int unsigned BlinkW   = 5;
  localparam int unsigned BlinkCntW = 6;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 9;

  localparam logic [LightW-1:0] ThresholdRst = 8'd170;
  localparam logic [MotorW-1:0] MotorTicksRst = 9'd480;
  localparam logic [CheckW-1:0] CheckIntRst  = 8'd20;
  localparam logic [BlinkW-1:0] BlinkIntRst  = 5'd15;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgThreshold  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMotorTicks = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCheckInt   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgBlinkInt   = 8'd3;

  // Bit positions in the indicator LED vector.
  localparam int unsigned LedOpen  = 0;
  localparam int unsigned LedMove  = 1;
  localparam int unsigned LedClose = 2;

  typedef struct packed {
    logic [LightW-1:0] light_threshold;
    logic [MotorW-1:0] motor_ticks;
    logic [CheckW-1:0] check_interval;
    logic [BlinkW-1:0] blink_interval;
  } lbmc_cfg_t;

  typedef struct packed {
    logic led_open_dir;
    logic led_moving;
    logic led_close_dir;
    logic blinds_open;
    logic moving;
  } lbmc_result_t;

endpackage

### src/lbmc_if.sv
interface lbmc_in_if;
  import lbmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [LightW-1:0] light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink (input valid, input light_sample, output ready);
endinterface

interface lbmc_out_if;
  logic valid;
  logic ready;
  logic led_open_dir;
  logic led_moving;
  logic led_close_dir;
  logic blinds_open;
  logic moving;

  modport source (output valid, output led_open_dir, output led_moving,
                  output led_close_dir, output blinds_open, output moving,
                  input ready);
  modport sink (input valid, input led_open_dir, input led_moving,
                input led_close_dir, input blinds_open, input moving,
                output ready);
endinterface

interface lbmc_cfg_if;
  import lbmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/lbmc_cfg_regs.sv
module lbmc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [lbmc_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [lbmc_pkg::CfgDataW-1:0] wr_data_i,
  output lbmc_pkg::lbmc_cfg_t       cfg_o
);
  import lbmc_pkg::*;

  lbmc_cfg_t cfg_q;

  // Writes to indexes beyond the register list fall into the default arm.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_threshold <= ThresholdRst;
      cfg_q.motor_ticks     <= MotorTicksRst;
      cfg_q.check_interval  <= CheckIntRst;
      cfg_q.blink_interval  <= BlinkIntRst;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CfgThreshold:  cfg_q.light_threshold <= wr_data_i[LightW-1:0];
        CfgMotorTicks: cfg_q.motor_ticks     <= wr_data_i[MotorW-1:0];
        CfgCheckInt:   cfg_q.check_interval  <= wr_data_i[CheckW-1:0];
        CfgBlinkInt:   cfg_q.blink_interval  <= wr_data_i[BlinkW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/lbmc_ctrl.sv
module lbmc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [lbmc_pkg::LightW-1:0] light_sample_i,
  input  lbmc_pkg::lbmc_cfg_t         cfg_i,
  output lbmc_pkg::lbmc_result_t      result_o
);
  import lbmc_pkg::*;

  logic [BlinkCntW-1:0] blink_count_q, blink_count_d;
  logic                 blink_active_q, blink_active_d;
  logic                 busy_q, busy_d;
  logic [MotorW-1:0]    motor_count_q, motor_count_d;
  logic [CheckW-1:0]    check_count_q, check_count_d;
  logic                 pos_open_q, pos_open_d;
  logic                 target_open_q, target_open_d;
  logic [2:0]           leds_q, leds_d;

  always_comb begin
    blink_count_d  = blink_count_q;
    blink_active_d = blink_active_q;
    busy_d         = busy_q;
    motor_count_d  = motor_count_q;
    check_count_d  = check_count_q;
    pos_open_d     = pos_open_q;
    target_open_d  = target_open_q;
    leds_d         = leds_q;

    // Blink: past the limit the count restarts so that it reads 2 afterwards.
    if (blink_active_q) begin
      if (blink_count_q > {1'b0, cfg_i.blink_interval}) begin
        leds_d[LedMove] = ~leds_q[LedMove];
        blink_count_d   = BlinkCntW'(2);
      end else begin
        blink_count_d = blink_count_q + BlinkCntW'(1);
      end
    end

    // Motor run-down.
    if (motor_count_q != '0) begin
      motor_count_d = motor_count_q - MotorW'(1);
    end else if (busy_q) begin
      leds_d[LedMove] = 1'b0;
      blink_active_d  = 1'b0;
      busy_d          = 1'b0;
      pos_open_d      = target_open_q;
    end

    // Periodic light check while idle.
    if (!busy_d) begin
      if (check_count_q >= cfg_i.check_interval) begin
        check_count_d = '0;
        if (light_sample_i > cfg_i.light_threshold) begin
          if (pos_open_d) begin
            leds_d[LedOpen]  = 1'b0;
            leds_d[LedClose] = 1'b1;
            motor_count_d    = cfg_i.motor_ticks;
            blink_active_d   = 1'b1;
            busy_d           = 1'b1;
            target_open_d    = 1'b0;
          end
        end else begin
          if (!pos_open_d) begin
            leds_d[LedClose] = 1'b0;
            leds_d[LedOpen]  = 1'b1;
            motor_count_d    = cfg_i.motor_ticks;
            blink_active_d   = 1'b1;
            busy_d           = 1'b1;
            target_open_d    = 1'b1;
          end
        end
      end else begin
        check_count_d = check_count_q + CheckW'(1);
      end
    end

    result_o.led_open_dir  = leds_d[LedOpen];
    result_o.led_moving    = leds_d[LedMove];
    result_o.led_close_dir = leds_d[LedClose];
    result_o.blinds_open   = pos_open_d;
    result_o.moving        = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_count_q  <= '0;
      blink_active_q <= 1'b0;
      busy_q         <= 1'b0;
      motor_count_q  <= '0;
      check_count_q  <= '0;
      pos_open_q     <= 1'b0;
      target_open_q  <= 1'b0;
      leds_q         <= '0;
    end else if (step_i) begin
      blink_count_q  <= blink_count_d;
      blink_active_q <= blink_active_d;
      busy_q         <= busy_d;
      motor_count_q  <= motor_count_d;
      check_count_q  <= check_count_d;
      pos_open_q     <= pos_open_d;
      target_open_q  <= target_open_d;
      leds_q         <= leds_d;
    end
  end

`ifndef SYNTHESIS
  a_blink_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_active_q == busy_q)
    else $error("blink activity out of step with the move");

  a_dir_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(leds_q[LedOpen] && leds_q[LedClose]))
    else $error("both direction LEDs lit");

  a_move_led_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leds_q[LedMove] |-> busy_q)
    else $error("moving LED lit with no move in progress");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(motor_count_q) && $stable(pos_open_q))
    else $error("state changed without a tick");
`endif

endmodule

### src/light_blind_motor_controller.sv
// Light-driven blind motor controller.
// Each item on light_i is one timer tick carrying a light sample; each tick
// yields exactly one item on result_o with the LED states, the blind
// position and the moving flag as they stand after that tick.
// cfg_i writes the threshold, motor run length, check interval and blink
// interval by register index 0 to 3; other indexes are ignored. cfg_i is
// always ready and should be written only while no tick is in flight.
// A tick accepted on light_i is captured in the input register, then evaluated
// and written to the result register once that register is free or being
// emptied, and is offered on result_o from then on.
// Throughput: one tick per cycle while result_o is ready, since the state
// update between the input register and the result register is combinational.
// When the receiver stalls, the result register holds its item and the
// input register holds one more tick; light_i then drops ready until the
// result is taken. Nothing is dropped.
// Reset clears all counters and flags, turns every LED off, marks the
// blinds closed and loads the default register values.
module light_blind_motor_controller (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbmc_in_if.sink   light_i,
  lbmc_cfg_if.sink  cfg_i,
  lbmc_out_if.source result_o
);
  import lbmc_pkg::*;

  logic              in_valid_q;
  logic [LightW-1:0] in_sample_q;
  logic              out_valid_q;
  lbmc_result_t      out_q;
  lbmc_result_t      step_result;
  lbmc_cfg_t         cfg;
  logic              step;
  logic              in_take;

  // A tick is evaluated when the result register is free or being emptied.
  assign step    = in_valid_q && (!out_valid_q || result_o.ready);
  assign light_i.ready = !in_valid_q || step;
  assign in_take = light_i.valid && light_i.ready;

  assign cfg_i.ready = 1'b1;

  lbmc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  lbmc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .light_sample_i (in_sample_q),
    .cfg_i          (cfg),
    .result_o       (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (light_i.ready) begin
        in_valid_q <= light_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= light_i.light_sample;
    end
    if (step) begin
      out_q <= step_result;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.led_open_dir  = out_q.led_open_dir;
  assign result_o.led_moving    = out_q.led_moving;
  assign result_o.led_close_dir = out_q.led_close_dir;
  assign result_o.blinds_open   = out_q.blinds_open;
  assign result_o.moving        = out_q.moving;

`ifndef SYNTHESIS
  a_stall_blocks_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !step)
    else $error("tick evaluated over an untaken result");

  a_full_stall_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !result_o.ready) |-> !light_i.ready)
    else $error("new item taken while both stages are full");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("evaluated tick left no result");
`endif

endmodule
